/* sv/aacp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package aacp_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OBJ_W    = 5;
  localparam int unsigned CORE_W   = 17;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned SBR_W    = 2;

  localparam logic [OBJ_W-1:0] ER_OBJ_FLOOR_RST = 5'd17;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RATE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CHANS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_OBJ   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EP_CONFIG = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LD_960    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_BAD_XRATE = 3'd7;

  // SBR signalling codes
  localparam logic [SBR_W-1:0] SBR_ABSENT  = 2'd0;
  localparam logic [SBR_W-1:0] SBR_PRESENT = 2'd1;
  localparam logic [SBR_W-1:0] SBR_NONE    = 2'd2;

  localparam logic [10:0]      SYNC_WORD      = 11'h2b7;
  localparam logic [3:0]       RATE_COUNT     = 4'd12;
  localparam logic [3:0]       ESCAPE_INDEX   = 4'd15;
  localparam logic [OUT_W-1:0] IMPLICIT_LIMIT = 24'd24000;
  localparam logic [OBJ_W-1:0] OBJ_SBR        = 5'd5;
  localparam logic [OBJ_W-1:0] OBJ_LTP        = 5'd4;

  function automatic logic [CORE_W-1:0] rate_hz(input logic [3:0] idx);
    logic [CORE_W-1:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/aacp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface aacp_bit_if;
  logic valid;
  logic ready;
  logic cfg_bit;
  logic last_bit;

  modport source (output valid, output cfg_bit, output last_bit, input ready);
  modport sink (input valid, input cfg_bit, input last_bit, output ready);
endinterface

interface aacp_res_if
  import aacp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OBJ_W-1:0]    object_type;
  logic [CORE_W-1:0]   core_rate;
  logic [OUT_W-1:0]    out_rate;
  logic [CHAN_W-1:0]   channel_count;
  logic [SBR_W-1:0]    sbr_state;
  logic                downsampled_sbr;
  logic                frame_length_flag;

  modport source (output valid, output status, output object_type, output core_rate,
                  output out_rate, output channel_count, output sbr_state,
                  output downsampled_sbr, output frame_length_flag, input ready);
  modport sink (input valid, input status, input object_type, input core_rate,
                input out_rate, input channel_count, input sbr_state,
                input downsampled_sbr, input frame_length_flag, output ready);
endinterface
`default_nettype wire

/* sv/aac_audio_config_parser_unit.sv */
// AAC audio-specific-config parser.
// bits: one config bit per item, most significant first; last_bit marks the
//   final bit of a config. result: one item per config, issued when parsing
//   completes, fails, or the data ends early. Bits that follow a result are
//   dropped until last_bit, which readies the parser for the next config.
// cfg_wr_en / cfg_wr_data: writes er_obj_floor, the first object type taken
//   as error resilient (reset 17); write it only while the parser is idle.
// The result is registered and valid in the cycle after the bit that finishes it.
// Throughput: one bit per cycle while bits.ready is high. Each bit advances the
//   field shifter and the phase register through one level of decode logic into
//   the state and result registers.
// Reset: the parser waits for the object type of a new config, the result
//   register is empty and er_obj_floor returns to 17.
// Stall: the result register holds its item while result.ready is low; a new
//   bit is still taken while the register is empty or being drained.
`timescale 1ns / 1ps
`default_nettype none
module aac_audio_config_parser_unit
  import aacp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  aacp_bit_if.sink              bits,
  aacp_res_if.source            result,
  input  wire logic             cfg_wr_en,
  input  wire logic [OBJ_W-1:0] cfg_wr_data
);

  localparam logic [4:0] P_OBJ     = 5'd0;
  localparam logic [4:0] P_RATE    = 5'd1;
  localparam logic [4:0] P_CHAN    = 5'd2;
  localparam logic [4:0] P_XRATE   = 5'd3;
  localparam logic [4:0] P_XFREQ   = 5'd4;
  localparam logic [4:0] P_OBJ2    = 5'd5;
  localparam logic [4:0] P_FLEN    = 5'd6;
  localparam logic [4:0] P_DEPCORE = 5'd7;
  localparam logic [4:0] P_DELAY   = 5'd8;
  localparam logic [4:0] P_EXTF    = 5'd9;
  localparam logic [4:0] P_RES     = 5'd10;
  localparam logic [4:0] P_EP      = 5'd11;
  localparam logic [4:0] P_SYNC    = 5'd12;
  localparam logic [4:0] P_SOBJ    = 5'd13;
  localparam logic [4:0] P_SFLAG   = 5'd14;
  localparam logic [4:0] P_SRATE   = 5'd15;
  localparam logic [4:0] P_SFREQ   = 5'd16;
  localparam logic [4:0] P_DONE    = 5'd17;

  localparam int unsigned F_FLEN = 0;
  localparam int unsigned F_DS   = 1;
  localparam int unsigned F_AUX  = 2;

  logic [OBJ_W-1:0]  er_obj_floor;
  logic [4:0]        phase, phase_next;
  logic [4:0]        bits_left, bits_left_next;
  logic [OUT_W-1:0]  field_shift, field_shift_next;
  logic [OBJ_W-1:0]  cur_object, cur_object_next;
  logic [OBJ_W-1:0]  first_object, first_object_next;
  logic [3:0]        rate_index, rate_index_next;
  logic [CHAN_W-1:0] chans, chans_next;
  logic [CORE_W-1:0] core_hz, core_hz_next;
  logic [OUT_W-1:0]  out_hz, out_hz_next;
  logic [SBR_W-1:0]  sbr_code, sbr_code_next;
  logic [2:0]        flags, flags_next;
  logic              out_valid;

  logic                accept;
  logic                do_emit;
  logic [STATUS_W-1:0] emit_status;
  logic                chk_obj, aft_ga, aft_ep;
  logic [3:0]          v4;

  assign bits.ready   = !out_valid || result.ready;
  assign accept       = bits.valid && bits.ready;
  assign result.valid = out_valid;

  always_comb begin
    phase_next        = phase;
    bits_left_next    = bits_left;
    field_shift_next  = field_shift;
    cur_object_next   = cur_object;
    first_object_next = first_object;
    rate_index_next   = rate_index;
    chans_next        = chans;
    core_hz_next      = core_hz;
    out_hz_next       = out_hz;
    sbr_code_next     = sbr_code;
    flags_next        = flags;
    do_emit           = 1'b0;
    emit_status       = ST_OK;
    chk_obj           = 1'b0;
    aft_ga            = 1'b0;
    aft_ep            = 1'b0;
    v4                = '0;

    if (accept) begin
      if (phase == P_DONE) begin
        if (bits.last_bit) begin
          phase_next     = P_OBJ;
          bits_left_next = '0;
        end
      end else begin
        // open a new config
        if (bits_left == '0) begin
          cur_object_next   = '0;
          first_object_next = '0;
          rate_index_next   = '0;
          chans_next        = '0;
          core_hz_next      = '0;
          out_hz_next       = '0;
          sbr_code_next     = SBR_NONE;
          flags_next        = '0;
          phase_next        = P_OBJ;
          bits_left_next    = 5'd5;
          field_shift_next  = '0;
        end
        field_shift_next = {field_shift_next[OUT_W-2:0], bits.cfg_bit};
        bits_left_next   = bits_left_next - 5'd1;
        v4               = field_shift_next[3:0];

        if (bits_left_next == '0) begin
          unique case (phase_next)
            P_OBJ: begin
              first_object_next = field_shift_next[OBJ_W-1:0];
              cur_object_next   = field_shift_next[OBJ_W-1:0];
              phase_next = P_RATE; bits_left_next = 5'd4; field_shift_next = '0;
            end
            P_RATE: begin
              rate_index_next = v4;
              if (v4 >= RATE_COUNT) begin
                do_emit = 1'b1; emit_status = ST_BAD_RATE;
              end else begin
                core_hz_next = rate_hz(v4);
                out_hz_next  = {{(OUT_W-CORE_W){1'b0}}, rate_hz(v4)};
                phase_next = P_CHAN; bits_left_next = 5'd4; field_shift_next = '0;
              end
            end
            P_CHAN: begin
              if (field_shift_next[OUT_W-1:CHAN_W] != '0) begin
                do_emit = 1'b1; emit_status = ST_BAD_CHANS;
              end else begin
                chans_next = field_shift_next[CHAN_W-1:0];
                if (first_object_next == OBJ_SBR) begin
                  sbr_code_next = SBR_PRESENT;
                  phase_next = P_XRATE; bits_left_next = 5'd4; field_shift_next = '0;
                end else begin
                  chk_obj = 1'b1;
                end
              end
            end
            P_XRATE: begin
              if (v4 == rate_index_next) flags_next[F_DS] = 1'b1;
              rate_index_next = v4;
              if (v4 == ESCAPE_INDEX) begin
                phase_next = P_XFREQ; bits_left_next = 5'd24; field_shift_next = '0;
              end else if (v4 >= RATE_COUNT) begin
                do_emit = 1'b1; emit_status = ST_BAD_XRATE;
              end else begin
                out_hz_next = {{(OUT_W-CORE_W){1'b0}}, rate_hz(v4)};
                phase_next = P_OBJ2; bits_left_next = 5'd5; field_shift_next = '0;
              end
            end
            P_XFREQ: begin
              out_hz_next = field_shift_next;
              phase_next = P_OBJ2; bits_left_next = 5'd5; field_shift_next = '0;
            end
            P_OBJ2: begin
              cur_object_next = field_shift_next[OBJ_W-1:0];
              chk_obj = 1'b1;
            end
            P_FLEN: begin
              if (field_shift_next[0]) flags_next[F_FLEN] = 1'b1;
              phase_next = P_DEPCORE; bits_left_next = 5'd1; field_shift_next = '0;
            end
            P_DEPCORE: begin
              if (field_shift_next[0]) begin
                phase_next = P_DELAY; bits_left_next = 5'd14;
              end else begin
                phase_next = P_EXTF; bits_left_next = 5'd1;
              end
              field_shift_next = '0;
            end
            P_DELAY: begin
              phase_next = P_EXTF; bits_left_next = 5'd1; field_shift_next = '0;
            end
            P_EXTF: begin
              if (field_shift_next[0] && (cur_object_next >= er_obj_floor)) begin
                phase_next = P_RES; bits_left_next = 5'd3; field_shift_next = '0;
              end else begin
                aft_ga = 1'b1;
              end
            end
            P_RES: aft_ga = 1'b1;
            P_EP: begin
              if (field_shift_next[1:0] != 2'd0) begin
                do_emit = 1'b1; emit_status = ST_EP_CONFIG;
              end else begin
                aft_ep = 1'b1;
              end
            end
            P_SYNC: begin
              if (field_shift_next[10:0] != SYNC_WORD) begin
                do_emit = 1'b1;
              end else begin
                phase_next = P_SOBJ; bits_left_next = 5'd5; field_shift_next = '0;
              end
            end
            P_SOBJ: begin
              if (field_shift_next[OBJ_W-1:0] != OBJ_SBR) begin
                do_emit = 1'b1;
              end else begin
                phase_next = P_SFLAG; bits_left_next = 5'd1; field_shift_next = '0;
              end
            end
            P_SFLAG: begin
              if (!field_shift_next[0]) begin
                sbr_code_next = SBR_ABSENT;
                do_emit = 1'b1;
              end else begin
                phase_next = P_SRATE; bits_left_next = 5'd4; field_shift_next = '0;
              end
            end
            P_SRATE: begin
              if (v4 == ESCAPE_INDEX) begin
                flags_next[F_AUX] = (v4 == rate_index_next);
                rate_index_next = v4;
                phase_next = P_SFREQ; bits_left_next = 5'd24; field_shift_next = '0;
              end else if (v4 >= RATE_COUNT) begin
                do_emit = 1'b1; emit_status = ST_BAD_XRATE;
              end else begin
                if (v4 == rate_index_next) flags_next[F_DS] = 1'b1;
                rate_index_next = v4;
                sbr_code_next   = SBR_PRESENT;
                out_hz_next     = {{(OUT_W-CORE_W){1'b0}}, rate_hz(v4)};
                do_emit = 1'b1;
              end
            end
            P_SFREQ: begin
              sbr_code_next = SBR_PRESENT;
              if (flags_next[F_AUX]) flags_next[F_DS] = 1'b1;
              out_hz_next = field_shift_next;
              do_emit = 1'b1;
            end
            default: begin
              do_emit = 1'b1; emit_status = ST_TRUNC;
            end
          endcase

          // object type check: general-audio types pass, ER types take the aux path
          if (chk_obj) begin
            flags_next[F_AUX] = 1'b0;
            if (cur_object_next == 5'd1 || cur_object_next == 5'd2 ||
                cur_object_next == 5'd3 || cur_object_next == 5'd4 ||
                cur_object_next == 5'd6 || cur_object_next == 5'd7) begin
              phase_next = P_FLEN; bits_left_next = 5'd1; field_shift_next = '0;
            end else if (cur_object_next >= er_obj_floor) begin
              flags_next[F_AUX] = 1'b1;
              phase_next = P_FLEN; bits_left_next = 5'd1; field_shift_next = '0;
            end else begin
              do_emit = 1'b1; emit_status = ST_BAD_OBJ;
            end
          end
          if (aft_ga) begin
            if (flags_next[F_AUX]) begin
              phase_next = P_EP; bits_left_next = 5'd2; field_shift_next = '0;
            end else begin
              aft_ep = 1'b1;
            end
          end
          if (aft_ep) begin
            if (cur_object_next == OBJ_LTP && flags_next[F_FLEN]) begin
              do_emit = 1'b1; emit_status = ST_LD_960;
            end else if (first_object_next == OBJ_SBR) begin
              do_emit = 1'b1;
            end else begin
              phase_next = P_SYNC; bits_left_next = 5'd11; field_shift_next = '0;
            end
          end
        end

        // data ended early; inside the sync extension this is a clean finish
        if (!do_emit && bits.last_bit) begin
          do_emit     = 1'b1;
          emit_status = (phase_next >= P_SYNC) ? ST_OK : ST_TRUNC;
        end

        if (do_emit) begin
          if (emit_status == ST_OK && sbr_code_next == SBR_NONE) begin
            if (out_hz_next <= IMPLICIT_LIMIT) begin
              out_hz_next = {out_hz_next[OUT_W-2:0], 1'b0};
            end else begin
              flags_next[F_DS] = 1'b1;
            end
          end
          phase_next     = P_DONE;
          bits_left_next = '0;
        end

        if (bits.last_bit) begin
          phase_next     = P_OBJ;
          bits_left_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      er_obj_floor <= ER_OBJ_FLOOR_RST;
      phase        <= P_OBJ;
      bits_left    <= '0;
      field_shift  <= '0;
      cur_object   <= '0;
      first_object <= '0;
      rate_index   <= '0;
      chans        <= '0;
      core_hz      <= '0;
      out_hz       <= '0;
      sbr_code     <= SBR_NONE;
      flags        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        er_obj_floor <= cfg_wr_data;
      end
      phase        <= phase_next;
      bits_left    <= bits_left_next;
      field_shift  <= field_shift_next;
      cur_object   <= cur_object_next;
      first_object <= first_object_next;
      rate_index   <= rate_index_next;
      chans        <= chans_next;
      core_hz      <= core_hz_next;
      out_hz       <= out_hz_next;
      sbr_code     <= sbr_code_next;
      flags        <= flags_next;
      if (do_emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register: payload needs no reset
  always_ff @(posedge clk) begin
    if (do_emit) begin
      result.status            <= emit_status;
      result.object_type       <= first_object_next;
      result.core_rate         <= core_hz_next;
      result.out_rate          <= out_hz_next;
      result.channel_count     <= chans_next;
      result.sbr_state         <= sbr_code_next;
      result.downsampled_sbr   <= flags_next[F_DS];
      result.frame_length_flag <= flags_next[F_FLEN];
    end
  end

  a_no_result_without_bit: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !$rose(out_valid))
    else $error("result appeared without an accepted bit");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> bits.ready)
    else $error("input stalled with an empty result register");

  a_bits_left_range: assert property (@(posedge clk) disable iff (rst)
    bits_left <= 5'd24)
    else $error("field length out of range");

  a_done_no_count: assert property (@(posedge clk) disable iff (rst)
    phase == P_DONE |-> bits_left == '0)
    else $error("finished config still counting bits");

  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    accept && bits.last_bit |=> phase == P_OBJ && bits_left == '0)
    else $error("last bit did not rearm the parser");

endmodule
`default_nettype wire
